>>> rtl/core/idht_pkg.sv
// Shared types and constants for the input debounce hold timer.
package idht_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned FLEN_W = 8;
  localparam int unsigned HOLD_W = 16;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 64;

  localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;

  localparam logic [63:0] FILTER_RESET = 64'h1414_1414_1414_1414;
  localparam logic [15:0] EDGE_RESET = 16'hAAAA;

  // Register select: paddr bit 3 picks the 8-byte register slot
  localparam logic REG_FILTER = 1'b0;
  localparam logic REG_EDGE = 1'b1;

  localparam logic [1:0] EDGE_FALL = 2'd0;
  localparam logic [1:0] EDGE_RISE = 2'd1;
  localparam logic [1:0] EDGE_BOTH = 2'd2;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_STATUS
  } state_t;

  // Edge event passed down the cell chain
  typedef struct packed {
    logic fire;
    logic level;
    logic [HOLD_W-1:0] hold;
  } ev_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic adopt;
    logic advance;
    logic shift;
  } cell_ctl_t;

endpackage

>>> rtl/core/idht_regs.sv
// APB configuration registers: filter lengths and edge selects.
module idht_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [idht_pkg::PADDR_W-1:0]  paddr,
  input  logic [idht_pkg::PDATA_W-1:0]  pwdata,
  output logic [idht_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [63:0]                   filter_table,
  output logic [15:0]                   edge_table
);
  import idht_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_table <= FILTER_RESET;
      edge_table <= EDGE_RESET;
    end else if (wr_en) begin
      if (paddr[3] == REG_FILTER) begin
        filter_table <= pwdata;
      end else begin
        edge_table <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    case (paddr[3])
      REG_FILTER: prdata = filter_table;
      REG_EDGE:   prdata = {48'd0, edge_table};
      default:    prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/idht_cell.sv
// One channel cell: latched level, filter counter, hold counter and scan token.
module idht_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  idht_pkg::cell_ctl_t           ctl,
  input  logic                          tok_in,
  output logic                          tok_out,
  input  logic                          pin,
  input  logic [idht_pkg::FLEN_W-1:0]   flen,
  input  logic [1:0]                    sel,
  input  idht_pkg::ev_t                 ev_in,
  output idht_pkg::ev_t                 ev_out,
  output logic                          level
);
  import idht_pkg::*;

  logic              token;
  logic              token_next;
  logic              stable;
  logic              stable_next;
  logic [FLEN_W-1:0] fcount;
  logic [FLEN_W-1:0] fcount_next;
  logic [HOLD_W-1:0] hold;
  logic [HOLD_W-1:0] hold_next;
  logic              fire;
  logic              sel_ok;

  assign sel_ok = (sel == EDGE_BOTH) || (sel == EDGE_RISE && pin) ||
                  (sel == EDGE_FALL && !pin);

  always_comb begin
    stable_next = stable;
    fcount_next = fcount;
    hold_next = hold;
    fire = 1'b0;
    token_next = ctl.shift ? tok_in : token;
    if (ctl.adopt) begin
      stable_next = pin;
      fcount_next = '0;
    end else if (ctl.advance && token) begin
      if (pin != stable) begin
        stable_next = pin;
        fcount_next = flen;
      end else if (fcount == '0) begin
        if (hold != HOLD_MAX) begin
          hold_next = hold + 1'b1;
        end
      end else begin
        fcount_next = fcount - 1'b1;
        // counter reaches zero this tick: report, then restart hold
        if (fcount == FLEN_W'(1)) begin
          fire = sel_ok;
          hold_next = HOLD_W'(flen);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
      stable <= 1'b0;
      fcount <= '0;
      hold <= '0;
    end else begin
      token <= token_next;
      stable <= stable_next;
      fcount <= fcount_next;
      hold <= hold_next;
    end
  end

  always_comb begin
    if (fire) begin
      ev_out.fire = 1'b1;
      ev_out.level = pin;
      ev_out.hold = hold;
    end else begin
      ev_out = ev_in;
    end
  end

  assign tok_out = token;
  assign level = stable;

endmodule

>>> rtl/core/input_debounce_hold_timer.sv
// Top level: debouncer with hold time, a chain of per-channel cells scanned per tick.
//
//   port group    role     payload
//   in_*          sink     pin_levels
//   out_*         source   item_kind, channel, new_level, event_hold, filtered_levels, last
//   APB           slave    filter_table (addr 0x0), edge_table (addr 0x8)
//
// A tick is accepted, then the scan token walks the cell chain one channel at
// a time while the output is free, then the status item is loaded. The
// adopting first tick after reset skips the scan. A stalled output holds
// the scan in place; the next tick is accepted once the status item is loaded.
// Reset clears all cell state and the primed flag; registers take their defaults.
module input_debounce_hold_timer #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [idht_pkg::PADDR_W-1:0]  paddr,
  input  logic [idht_pkg::PDATA_W-1:0]  pwdata,
  output logic [idht_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    pin_levels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          item_kind,
  output logic [2:0]                    channel,
  output logic                          new_level,
  output logic [15:0]                   event_hold,
  output logic [7:0]                    filtered_levels,
  output logic                          last
);
  import idht_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  logic [63:0]        filter_table;
  logic [15:0]        edge_table;
  state_t             state;
  state_t             state_next;
  logic               primed;
  logic [LEVEL_W-1:0] pin_reg;
  logic [IDX_W-1:0]   step;
  logic               accept;
  logic               out_free;
  logic               start;
  cell_ctl_t          ctl;
  logic               load_ev;
  logic               load_status;
  logic [LEVEL_W-1:0] filt;

  logic [CHANNELS-1:0] tok;
  logic [CHANNELS-1:0] lvl;
  logic [CHANNELS-1:0] cell_pin;
  ev_t                 ev_chain [CHANNELS+1];

  idht_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .filter_table (filter_table),
    .edge_table   (edge_table)
  );

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign start = accept && primed;

  assign ctl.adopt = accept && !primed;
  assign ctl.advance = (state == ST_RUN) && out_free;
  assign ctl.shift = start || ctl.advance;

  assign ev_chain[0] = '0;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    assign cell_pin[g] = ctl.adopt ? pin_levels[g] : pin_reg[g];
    idht_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .tok_in  ((g == 0) ? start : tok[(g == 0) ? 0 : g-1]),
      .tok_out (tok[g]),
      .pin     (cell_pin[g]),
      .flen    (filter_table[8*g +: 8]),
      .sel     (edge_table[2*g +: 2]),
      .ev_in   (ev_chain[g]),
      .ev_out  (ev_chain[g+1]),
      .level   (lvl[g])
    );
  end

  always_comb begin
    filt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      filt[i] = lvl[i];
    end
  end

  always_comb begin
    state_next = state;
    load_ev = 1'b0;
    load_status = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = primed ? ST_RUN : ST_STATUS;
        end
      end
      ST_RUN: begin
        if (ctl.advance) begin
          load_ev = ev_chain[CHANNELS].fire;
          if (step == LAST_IDX) begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          load_status = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      primed <= 1'b0;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        primed <= 1'b1;
        step <= '0;
      end else if (ctl.advance) begin
        step <= step + 1'b1;
      end
      if (load_ev || load_status) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin_reg <= pin_levels;
    end
    if (load_ev) begin
      item_kind <= KIND_EDGE;
      channel <= 3'(step);
      new_level <= ev_chain[CHANNELS].level;
      event_hold <= ev_chain[CHANNELS].hold;
      filtered_levels <= '0;
      last <= 1'b0;
    end else if (load_status) begin
      item_kind <= KIND_STATUS;
      channel <= '0;
      new_level <= 1'b0;
      event_hold <= '0;
      filtered_levels <= filt;
      last <= 1'b1;
    end
  end

endmodule

>>> tb/input_debounce_hold_timer_tb.sv
// Self-checking testbench for the input debounce hold timer: directed ticks, hold soak, random ticks.
`timescale 1ns / 1ps

module input_debounce_hold_timer_tb;
  import idht_pkg::*;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned IDLE_LIMIT = 3000;
  // a short run of stable ticks so the hold counts climb before every channel flips
  localparam int unsigned SOAK_TICKS = 12;
  localparam logic [PADDR_W-1:0] ADDR_FILTER = {REG_FILTER, 3'b000};
  localparam logic [PADDR_W-1:0] ADDR_EDGE = {REG_EDGE, 3'b000};

  typedef struct packed {
    logic kind;
    logic [2:0] chan;
    logic level;
    logic [HOLD_W-1:0] hold;
    logic [LEVEL_W-1:0] levels;
    logic last;
  } tick_result_t;

  typedef struct packed {
    logic [7:0] pins;
    logic typed;
    logic [7:0] levels;
  } stim_row_t;

  // Typed status only on the adopting tick and the all-low / all-high rows
  localparam int NUM_ROWS = 25;
  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    '{8'h00, 1'b1, 8'h00},
    '{8'hFF, 1'b1, 8'hFF},
    '{8'hFF, 1'b1, 8'hFF},
    '{8'hFF, 1'b1, 8'hFF},
    '{8'hFF, 1'b1, 8'hFF},
    '{8'h00, 1'b1, 8'h00},
    '{8'h00, 1'b1, 8'h00},
    '{8'h00, 1'b1, 8'h00},
    '{8'h00, 1'b1, 8'h00},
    '{8'h55, 1'b0, 8'h00},
    '{8'h55, 1'b0, 8'h00},
    '{8'hAA, 1'b0, 8'h00},
    '{8'hAA, 1'b0, 8'h00},
    '{8'hAA, 1'b0, 8'h00},
    '{8'h0F, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 8'h00},
    '{8'h01, 1'b0, 8'h00},
    '{8'h00, 1'b1, 8'h00},
    '{8'h00, 1'b1, 8'h00},
    '{8'h40, 1'b0, 8'h00},
    '{8'h40, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 8'hFF}
  };

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] pin_levels = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic item_kind;
  logic [2:0] channel;
  logic new_level;
  logic [15:0] event_hold;
  logic [7:0] filtered_levels;
  logic last;

  // Shadow of the debouncer
  logic [LEVEL_W-1:0] settled;
  logic [FLEN_W-1:0] filt_cnt [CHANNELS];
  logic [HOLD_W-1:0] hold_cnt [CHANNELS];
  logic primed;
  logic [63:0] filter_cfg;
  logic [15:0] edge_cfg;

  tick_result_t awaited[$];
  tick_result_t want;
  int fail_count = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit rx_stall_on = 1'b0;
  logic [7:0] last_pins = '0;

  input_debounce_hold_timer #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pin_levels(pin_levels),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .item_kind(item_kind),
    .channel(channel),
    .new_level(new_level),
    .event_hold(event_hold),
    .filtered_levels(filtered_levels),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance the shadow by one tick and queue the results it causes
  function automatic void debounce_tick(logic [7:0] pins, logic typed,
                                        logic [7:0] typed_levels);
    logic [FLEN_W-1:0] flen;
    logic [1:0] sel;
    logic lvl;
    tick_result_t r;
    for (int i = 0; i < CHANNELS; i++) begin
      lvl = pins[i];
      flen = filter_cfg[8*i +: 8];
      sel = edge_cfg[2*i +: 2];
      if (!primed) begin
        settled[i] = lvl;
        filt_cnt[i] = '0;
      end else if (lvl != settled[i]) begin
        settled[i] = lvl;
        filt_cnt[i] = flen;
      end else if (filt_cnt[i] == '0) begin
        if (hold_cnt[i] != HOLD_MAX) hold_cnt[i] = hold_cnt[i] + 1'b1;
      end else begin
        filt_cnt[i] = filt_cnt[i] - 1'b1;
        if (filt_cnt[i] == '0) begin
          if (sel == EDGE_BOTH || (sel == EDGE_FALL && !lvl) || (sel == EDGE_RISE && lvl)) begin
            r = '{KIND_EDGE, 3'(i), lvl, hold_cnt[i], 8'h00, 1'b0};
            awaited.push_back(r);
          end
          // event carries the old hold, then restart from the filter length
          hold_cnt[i] = flen;
        end
      end
    end
    primed = 1'b1;
    r = '{KIND_STATUS, 3'd0, 1'b0, 16'h0000, typed ? typed_levels : settled, 1'b1};
    awaited.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: kind %0d channel %0d", item_kind, channel);
        fail_count++;
      end else begin
        want = awaited.pop_front();
        check_field("item_kind", want.kind, item_kind);
        check_field("channel", want.chan, channel);
        check_field("new_level", want.level, new_level);
        check_field("event_hold", want.hold, event_hold);
        check_field("filtered_levels", want.levels, filtered_levels);
        check_field("last", want.last, last);
      end
    end
  end

  // Receiver: ready by default, with random stretches of stall while rx_stall_on is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (rx_stall_on && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Present one tick and hold it until accepted; valid is left high
  task automatic send_tick(logic [7:0] pins, logic typed, logic [7:0] typed_levels);
    in_valid <= 1'b1;
    pin_levels <= pins;
    do @(posedge clk); while (!in_ready);
    debounce_tick(pins, typed, typed_levels);
    last_pins = pins;
  endtask

  task automatic settle();
    while (awaited.size() != 0) @(posedge clk);
    repeat (CHANNELS + 4) @(posedge clk);
  endtask

  // Setup then access; psel stays up so a second write can follow directly
  task automatic program_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[3] == REG_EDGE) edge_cfg = data[15:0];
    else filter_cfg = data;
  endtask

  task automatic reconfigure(logic [63:0] flt, logic [15:0] edg);
    settle();
    program_reg(ADDR_FILTER, flt);
    program_reg(ADDR_EDGE, {48'h0, edg});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Random ticks: each bit flips with flip_pct percent, now and then a wild item
  task automatic run_ticks(int count, int flip_pct, bit tx_idle);
    int sent;
    int burst;
    logic [7:0] pins;
    sent = 0;
    while (sent < count) begin
      burst = tx_idle ? $urandom_range(1, 16) : count;
      for (int k = 0; k < burst && sent < count; k++) begin
        pins = last_pins;
        if ($urandom_range(0, 19) == 0) begin
          pins = 8'($urandom);
        end else begin
          for (int b = 0; b < 8; b++) begin
            if ($urandom_range(0, 99) < flip_pct) pins[b] = ~pins[b];
          end
        end
        send_tick(pins, 1'b0, 8'h00);
        sent++;
      end
      in_valid <= 1'b0;
      if (tx_idle) repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    logic [63:0] flt;
    logic [15:0] edg;
    filter_cfg = FILTER_RESET;
    edge_cfg = EDGE_RESET;
    settled = '0;
    primed = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      filt_cnt[i] = '0;
      hold_cnt[i] = '0;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Lengths 1,1,1,1,2,0,255,3; selects fall,rise,both,three,both,both,both,rise
    rx_stall_on = 1'b1;
    reconfigure(64'h03FF_0002_0101_0101, 16'h6AE4);
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_tick(STIM_ROWS[r].pins, STIM_ROWS[r].typed, STIM_ROWS[r].levels);
    end
    in_valid <= 1'b0;

    // Hold every level for a stretch, then flip all channels
    rx_stall_on = 1'b0;
    reconfigure(64'h0001_0101_0101_0101, EDGE_RESET);
    repeat (SOAK_TICKS) send_tick(last_pins, 1'b0, 8'h00);
    send_tick(~last_pins, 1'b0, 8'h00);
    send_tick(last_pins, 1'b0, 8'h00);
    send_tick(last_pins, 1'b0, 8'h00);
    in_valid <= 1'b0;

    rx_stall_on = 1'b1;
    reconfigure(FILTER_RESET, EDGE_RESET);
    run_ticks(60, 2, 1'b1);
    reconfigure(64'h0, 16'h0000);
    run_ticks(30, 30, 1'b1);
    reconfigure({64{1'b1}}, 16'hFFFF);
    run_ticks(30, 30, 1'b0);

    for (int p = 0; p < 5; p++) begin
      for (int b = 0; b < 8; b++) begin
        flt[8*b +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 4));
      end
      edg = 16'($urandom);
      rx_stall_on = (p != 2);
      reconfigure(flt, edg);
      run_ticks(40, 15, p != 1);
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
